// ===== hw/rtl/lpbt_pkg.sv =====
// shared types and constants of the page buffer tag store
// no dependencies
package lpbt_pkg;
  localparam int NUM_FRAMES = 16;
  localparam int FW = $clog2(NUM_FRAMES);

  localparam logic [1:0] CMD_GET   = 2'd0;
  localparam logic [1:0] CMD_PUT   = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_NOFREE  = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_FLUSH   = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  req_table;
    logic [31:0] req_page;
    logic [3:0]  slot;
    logic        set_dirty;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  slot_res;
    logic [2:0]  status;
    logic        write_back;
    logic [9:0]  wb_table;
    logic [31:0] wb_page;
    logic        read_needed;
    logic        last;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input beat
    logic scan_clr;   // restart frame index at 0
    logic scan_step;  // advance the index
    logic do_get;     // resolve get: hit or victim
    logic do_put;     // apply put
    logic do_close;   // flush the frame at the index if it matches
    logic emit_get;   // load the get result
    logic emit_put;
    logic emit_flush; // flush entry result for the indexed frame
    logic emit_done;  // final close result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       tbl_zero;
    logic       scan_end;   // index is the last frame
    logic       close_hit;  // indexed frame belongs to the table
  } sts_t;
endpackage

// ===== hw/rtl/lpbt_datapath.sv =====
// frame tag, pin, dirty and recency registers with hit and victim logic
// depends on lpbt_pkg
module lpbt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  lpbt_pkg::in_beat_t  in_data,
  input  lpbt_pkg::cmd_t      cmd,
  output lpbt_pkg::sts_t      sts,
  output lpbt_pkg::out_beat_t res
);
  localparam int N = lpbt_pkg::NUM_FRAMES;
  localparam int W = lpbt_pkg::FW;

  logic [9:0]  tbl_r   [N];
  logic [31:0] page_r  [N];
  logic [7:0]  pin_r   [N];
  logic        dirty_r [N];
  logic [W-1:0] rank_r [N];
  lpbt_pkg::in_beat_t req_r;
  logic [W-1:0] idx_r;
  lpbt_pkg::out_beat_t res_r, res_nxt;

  // hit select and victim select, both flat across the frames
  logic hit_any, vic_any;
  logic [W-1:0] hit_idx, vic_idx;
  logic [N-1:0] free_by_rank;
  logic [W-1:0] frame_of_rank [N];
  always_comb begin
    hit_any = 1'b0; hit_idx = '0;
    vic_any = 1'b0; vic_idx = '0;
    free_by_rank = '0;
    for (int r = 0; r < N; r++) frame_of_rank[r] = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (tbl_r[i] == req_r.req_table && page_r[i] == req_r.req_page) begin
        hit_any = 1'b1; hit_idx = W'(i);
      end
    end
    // ranks are a permutation: order frames by rank, pick the highest free rank
    for (int i = 0; i < N; i++) begin
      free_by_rank[rank_r[i]] = (pin_r[i] == 8'd0);
      frame_of_rank[rank_r[i]] = W'(i);
    end
    for (int r = 0; r < N; r++) begin
      if (free_by_rank[r]) begin
        vic_any = 1'b1; vic_idx = frame_of_rank[r];
      end
    end
  end

  logic slot_ok;
  assign slot_ok = ({1'b0, req_r.slot} < (W + 1 > 4 ? (W + 1)'(N) : 5'(N)));
  logic [W-1:0] put_idx;
  assign put_idx = W'(req_r.slot);

  assign sts.command   = req_r.command;
  assign sts.tbl_zero  = (req_r.req_table == 10'd0);
  assign sts.scan_end  = (idx_r == W'(N - 1));
  assign sts.close_hit = (tbl_r[idx_r] == req_r.req_table);

  always_comb begin
    res_nxt = res_r;
    if (cmd.emit_get) begin
      res_nxt = '0;
      res_nxt.last = 1'b1;
      if (sts.tbl_zero || (!hit_any && !vic_any)) begin
        res_nxt.status = lpbt_pkg::ST_NOFREE;
      end else if (hit_any) begin
        res_nxt.status = lpbt_pkg::ST_HIT;
        res_nxt.slot_res = 4'(hit_idx);
      end else begin
        res_nxt.status = lpbt_pkg::ST_MISS;
        res_nxt.slot_res = 4'(vic_idx);
        res_nxt.read_needed = 1'b1;
        if (dirty_r[vic_idx]) begin
          res_nxt.write_back = 1'b1;
          res_nxt.wb_table = tbl_r[vic_idx];
          res_nxt.wb_page = page_r[vic_idx];
        end
      end
    end else if (cmd.emit_put) begin
      res_nxt = '0;
      res_nxt.status = lpbt_pkg::ST_RELEASE;
      res_nxt.slot_res = req_r.slot;
      res_nxt.last = 1'b1;
    end else if (cmd.emit_flush) begin
      res_nxt = '0;
      res_nxt.status = lpbt_pkg::ST_FLUSH;
      res_nxt.slot_res = 4'(idx_r);
      if (dirty_r[idx_r]) begin
        res_nxt.write_back = 1'b1;
        res_nxt.wb_table = tbl_r[idx_r];
        res_nxt.wb_page = page_r[idx_r];
      end
    end else if (cmd.emit_done) begin
      res_nxt = '0;
      res_nxt.status = lpbt_pkg::ST_FLUSH;
      res_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.load) req_r <= in_data;
    if (cmd.scan_clr) idx_r <= '0;
    else if (cmd.scan_step) idx_r <= idx_r + W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        tbl_r[i] <= '0; page_r[i] <= '0; pin_r[i] <= '0;
        dirty_r[i] <= 1'b0; rank_r[i] <= W'(i);
      end
    end else begin
      if (cmd.do_get && !sts.tbl_zero) begin
        if (hit_any) begin
          if (pin_r[hit_idx] != 8'hff) pin_r[hit_idx] <= pin_r[hit_idx] + 8'd1;
        end else if (vic_any) begin
          tbl_r[vic_idx] <= req_r.req_table;
          page_r[vic_idx] <= req_r.req_page;
          pin_r[vic_idx] <= 8'd1;
          dirty_r[vic_idx] <= 1'b0;
        end
      end
      if (cmd.do_put && slot_ok) begin
        if (pin_r[put_idx] != 8'd0) pin_r[put_idx] <= pin_r[put_idx] - 8'd1;
        if (req_r.set_dirty && tbl_r[put_idx] != 10'd0) dirty_r[put_idx] <= 1'b1;
        for (int i = 0; i < N; i++) begin
          if (rank_r[i] < rank_r[put_idx]) rank_r[i] <= rank_r[i] + W'(1);
        end
        rank_r[put_idx] <= '0;
      end
      if (cmd.do_close && sts.close_hit) begin
        tbl_r[idx_r] <= '0; page_r[idx_r] <= '0;
        pin_r[idx_r] <= '0; dirty_r[idx_r] <= 1'b0;
      end
    end
  end

  assign res = res_r;

  // only one result source per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_get, cmd.emit_put, cmd.emit_flush, cmd.emit_done}))
    else $error("two result sources at once");
  // a closed frame is empty afterwards
  a_close_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_close && sts.close_hit && !sts.tbl_zero |=> tbl_r[$past(idx_r)] == 10'd0)
    else $error("closed frame still tagged");
  // a filled victim holds pin count one
  a_fill_pin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_get && !sts.tbl_zero && !hit_any && vic_any |=> pin_r[$past(vic_idx)] == 8'd1)
    else $error("victim not pinned");
endmodule

// ===== hw/rtl/lpbt_ctrl.sv =====
// command sequencer: handshakes, close scan and result hold
// depends on lpbt_pkg
module lpbt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  lpbt_pkg::sts_t   sts,
  output lpbt_pkg::cmd_t   cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic valid_r, valid_nxt;
  logic free;
  assign free = !valid_r || !out_stall;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    valid_nxt = valid_r && out_stall;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1; cmd.scan_clr = 1'b1; state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.command)
          lpbt_pkg::CMD_GET: if (free) begin
            cmd.do_get = 1'b1; cmd.emit_get = 1'b1; valid_nxt = 1'b1; state_nxt = S_IDLE;
          end
          lpbt_pkg::CMD_PUT: if (free) begin
            cmd.do_put = 1'b1; cmd.emit_put = 1'b1; valid_nxt = 1'b1; state_nxt = S_IDLE;
          end
          lpbt_pkg::CMD_CLOSE: state_nxt = sts.tbl_zero ? S_DONE : S_SCAN;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (sts.close_hit) begin
          if (free) begin
            cmd.emit_flush = 1'b1; cmd.do_close = 1'b1; valid_nxt = 1'b1;
            cmd.scan_step = 1'b1;
            state_nxt = sts.scan_end ? S_DONE : S_SCAN;
          end
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_end) state_nxt = S_DONE;
        end
      end
      S_DONE: if (free) begin
        cmd.emit_done = 1'b1; valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

  // a result never gets overwritten while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |-> !(cmd.emit_get || cmd.emit_put || cmd.emit_flush || cmd.emit_done))
    else $error("stalled result overwritten");
  // input only taken while idle
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == S_IDLE)
    else $error("input taken while busy");
  // flush only during the scan
  a_flush_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_close |-> state_r == S_SCAN)
    else $error("flush outside scan");
endmodule

// ===== hw/rtl/lru_page_buffer_tags.sv =====
// top level of the page buffer tag and lru store
// depends on lpbt_pkg, lpbt_ctrl, lpbt_datapath
//
// usage
//   in channel: one command beat (get, put, close) with in_valid / in_stall
//   out channel: result beats with out_valid / out_stall; last marks the
//   final beat of a command
//   one command is worked at a time; in_stall is high from acceptance until
//   the command's final beat is loaded into the output register
//   get and put: one beat, loaded into the output register from the exec
//   state once the receiver keeps up; hit compare and lru victim pick run
//   across all frames combinationally from registered tags
//   close: a scan of the frames, one frame a cycle unless a flush beat is
//   stalled; one flush beat for each frame of the table, then a done beat
//   reset: all frames empty, clean and unpinned, recency rank equals index
//   receiver stall: the output register holds its beat and the scan waits
//   before loading the next one; other work waits the same way
module lru_page_buffer_tags (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpbt_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpbt_pkg::out_beat_t out_data
);
  lpbt_pkg::cmd_t cmd;
  lpbt_pkg::sts_t sts;

  // sequencer
  lpbt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  // frame state and result register
  lpbt_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data), .cmd(cmd), .sts(sts), .res(out_data)
  );
endmodule
